// ===== design/clp_pkg.sv =====
// Shared types, register codes and vertex classification for the plane clipper.
`default_nettype none
package clp_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_X  = 3'd0,
		REG_POINT_Y  = 3'd1,
		REG_POINT_Z  = 3'd2,
		REG_NORMAL_X = 3'd3,
		REG_NORMAL_Y = 3'd4,
		REG_NORMAL_Z = 3'd5
	} cfg_reg_e;

	// inside count plus inside/outside vertex lists in v1, v2, v3 order
	typedef struct packed {
		logic [1:0] n_in;
		logic [1:0] i0;
		logic [1:0] i1;
		logic [1:0] o0;
		logic [1:0] o1;
	} clp_class_t;

	// bit i of neg set means vertex i lies on the dropped side
	function automatic clp_class_t classify(input logic [2:0] neg);
		clp_class_t c;
		c = '0;
		unique case (neg)
			3'b000: begin c.n_in = 2'd3; c.i0 = 2'd0; c.i1 = 2'd1; end
			3'b001: begin c.n_in = 2'd2; c.i0 = 2'd1; c.i1 = 2'd2; c.o0 = 2'd0; end
			3'b010: begin c.n_in = 2'd2; c.i0 = 2'd0; c.i1 = 2'd2; c.o0 = 2'd1; end
			3'b100: begin c.n_in = 2'd2; c.i0 = 2'd0; c.i1 = 2'd1; c.o0 = 2'd2; end
			3'b011: begin c.n_in = 2'd1; c.i0 = 2'd2; c.o0 = 2'd0; c.o1 = 2'd1; end
			3'b101: begin c.n_in = 2'd1; c.i0 = 2'd1; c.o0 = 2'd0; c.o1 = 2'd2; end
			3'b110: begin c.n_in = 2'd1; c.i0 = 2'd0; c.o0 = 2'd1; c.o1 = 2'd2; end
			3'b111: begin c.n_in = 2'd0; end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/clp_in_if.sv =====
// Input triangle channel.
`default_nettype none
interface clp_in_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] v1_x, v1_y, v1_z;
	logic signed [W-1:0] v2_x, v2_y, v2_z;
	logic signed [W-1:0] v3_x, v3_y, v3_z;
	logic [15:0]         color;
	logic [15:0]         glyph;

	modport source(output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
		color, glyph, input ready);
	modport sink(input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
		color, glyph, output ready);
endinterface
`default_nettype wire

// ===== design/clp_out_if.sv =====
// Output triangle channel.
`default_nettype none
interface clp_out_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] out_v1_x, out_v1_y, out_v1_z;
	logic signed [W-1:0] out_v2_x, out_v2_y, out_v2_z;
	logic signed [W-1:0] out_v3_x, out_v3_y, out_v3_z;
	logic [15:0]         out_color;
	logic [15:0]         out_glyph;
	logic                last;

	modport source(output valid, out_v1_x, out_v1_y, out_v1_z, out_v2_x, out_v2_y,
		out_v2_z, out_v3_x, out_v3_y, out_v3_z, out_color, out_glyph, last, input ready);
	modport sink(input valid, out_v1_x, out_v1_y, out_v1_z, out_v2_x, out_v2_y,
		out_v2_z, out_v3_x, out_v3_y, out_v3_z, out_color, out_glyph, last, output ready);
endinterface
`default_nettype wire

// ===== design/clp_cfg_if.sv =====
// Configuration write channel.
`default_nettype none
interface clp_cfg_if import clp_pkg::*; #(parameter int W = 32);
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [W-1:0]         data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/triangle_plane_clipper_top.sv =====
// Top level of the triangle plane clipper: config registers, pipeline, dividers, output.
//
// Clips each input triangle against the plane n . (q - p) >= 0 held in six
// configuration registers and returns zero, one or two triangles. A triangle
// transaction can be accepted every cycle unless the pipeline holds; each result
// triangle takes one output transaction, so an input that splits into two
// triangles occupies the output for two transactions and a stream of such inputs
// is limited by the single output register. From input to first result a
// triangle passes three stages of plane distance and classification, one stage of
// edge selection, the divider pipelines (two partial-product stages, one stage per
// quotient bit, one rounding stage) and the output register. The whole pipeline
// holds when the output register is full and its last triangle is not taken, unless
// the last pipeline stage is empty or carries a fully clipped triangle. Write the
// configuration only while no triangle is in flight; writes always complete at once.
`default_nettype none
module triangle_plane_clipper_top import clp_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	clp_in_if.sink    tri_in,
	clp_out_if.source tri_out,
	clp_cfg_if.sink   cfg
);
	localparam int W       = COORD_WIDTH;
	localparam int DW      = 2*W + 3;
	localparam int DIV_LAT = W + 3;

	logic signed [W-1:0] point_q [3];
	logic signed [W-1:0] normal_q [3];

	logic                adv;
	logic signed [W-1:0] vin [3][3];

	logic                valid_s3;
	logic signed [W-1:0] vtx_s3 [3][3];
	logic [15:0]         color_s3, glyph_s3;
	logic signed [DW-1:0] dist_s3 [3];
	clp_class_t          cls_s3;

	// edge selection stage
	logic [1:0]          ai [2];
	logic [1:0]          bi [2];
	logic                valid_s4;
	logic signed [W-1:0] vtx_s4 [3][3];
	clp_class_t          cls_s4;
	logic [15:0]         color_s4, glyph_s4;
	logic signed [W-1:0] a_s4 [2][3];
	logic [W-1:0]        mag_s4 [2][3];
	logic                neg_s4 [2][3];
	logic [2*W+1:0]      da_s4 [2];
	logic [DW-1:0]       den_s4 [2];

	// side path matching the divider latency
	logic                valid_sn [DIV_LAT];
	logic signed [W-1:0] vtx_sn [DIV_LAT][3][3];
	clp_class_t          cls_sn [DIV_LAT];
	logic [15:0]         color_sn [DIV_LAT];
	logic [15:0]         glyph_sn [DIV_LAT];

	logic signed [W-1:0] x_res [2][3];
	logic                can_load;
	logic                v_fin;
	clp_class_t          cls_fin;

	// configuration registers; unknown indexes are ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q[0]  <= '0;
			point_q[1]  <= '0;
			point_q[2]  <= '0;
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
		end else if (cfg.valid) begin
			unique case (cfg_reg_e'(cfg.index))
				REG_POINT_X:  point_q[0]  <= cfg.data;
				REG_POINT_Y:  point_q[1]  <= cfg.data;
				REG_POINT_Z:  point_q[2]  <= cfg.data;
				REG_NORMAL_X: normal_q[0] <= cfg.data;
				REG_NORMAL_Y: normal_q[1] <= cfg.data;
				REG_NORMAL_Z: normal_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// advance when the output can take the last stage, or it holds nothing to deliver
	assign adv          = !v_fin || can_load || (cls_fin.n_in == 2'd0);
	assign tri_in.ready = adv;

	assign vin[0][0] = tri_in.v1_x;
	assign vin[0][1] = tri_in.v1_y;
	assign vin[0][2] = tri_in.v1_z;
	assign vin[1][0] = tri_in.v2_x;
	assign vin[1][1] = tri_in.v2_y;
	assign vin[1][2] = tri_in.v2_z;
	assign vin[2][0] = tri_in.v3_x;
	assign vin[2][1] = tri_in.v3_y;
	assign vin[2][2] = tri_in.v3_z;

	clp_dist #(.W(W)) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (tri_in.valid),
		.vin      (vin),
		.color_in (tri_in.color),
		.glyph_in (tri_in.glyph),
		.point    (point_q),
		.normal   (normal_q),
		.valid_s3 (valid_s3),
		.vtx_s3   (vtx_s3),
		.color_s3 (color_s3),
		.glyph_s3 (glyph_s3),
		.dist_s3  (dist_s3),
		.cls_s3   (cls_s3)
	);

	// lane 0 cuts edge (i0, o0); lane 1 cuts (i0, o1) with one vertex inside,
	// (i1, o0) with two inside
	always_comb begin
		ai[0] = cls_s3.i0;
		bi[0] = cls_s3.o0;
		ai[1] = (cls_s3.n_in == 2'd1) ? cls_s3.i0 : cls_s3.i1;
		bi[1] = (cls_s3.n_in == 2'd1) ? cls_s3.o1 : cls_s3.o0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (adv)
			valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				for (int k = 0; k < 3; k++) begin
					logic signed [W:0] diff;
					diff = {vtx_s3[bi[l]][k][W-1], vtx_s3[bi[l]][k]}
						- {vtx_s3[ai[l]][k][W-1], vtx_s3[ai[l]][k]};
					a_s4[l][k]   <= vtx_s3[ai[l]][k];
					neg_s4[l][k] <= diff[W];
					mag_s4[l][k] <= diff[W] ? W'(-diff) : W'(diff);
				end
				da_s4[l]  <= dist_s3[ai[l]][2*W+1:0];
				den_s4[l] <= DW'({dist_s3[ai[l]][DW-1], dist_s3[ai[l]]}
					- {dist_s3[bi[l]][DW-1], dist_s3[bi[l]]});
			end
			vtx_s4   <= vtx_s3;
			cls_s4   <= cls_s3;
			color_s4 <= color_s3;
			glyph_s4 <= glyph_s3;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar k = 0; k < 3; k++) begin : g_coord
			clp_div #(.W(W)) u_div (
				.clk  (clk),
				.en   (adv),
				.a    (a_s4[l][k]),
				.mag  (mag_s4[l][k]),
				.neg  (neg_s4[l][k]),
				.da   (da_s4[l]),
				.den  (den_s4[l]),
				.res  (x_res[l][k])
			);
		end
	end

	// carry vertices and tags alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < DIV_LAT; s++) valid_sn[s] <= 1'b0;
		end else if (adv) begin
			valid_sn[0] <= valid_s4;
			for (int s = 1; s < DIV_LAT; s++) valid_sn[s] <= valid_sn[s-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vtx_sn[0]   <= vtx_s4;
			cls_sn[0]   <= cls_s4;
			color_sn[0] <= color_s4;
			glyph_sn[0] <= glyph_s4;
			for (int s = 1; s < DIV_LAT; s++) begin
				vtx_sn[s]   <= vtx_sn[s-1];
				cls_sn[s]   <= cls_sn[s-1];
				color_sn[s] <= color_sn[s-1];
				glyph_sn[s] <= glyph_sn[s-1];
			end
		end
	end

	assign v_fin   = valid_sn[DIV_LAT-1];
	assign cls_fin = cls_sn[DIV_LAT-1];

	clp_emit #(.W(W)) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_fin),
		.cls      (cls_fin),
		.vtx      (vtx_sn[DIV_LAT-1]),
		.x0       (x_res[0]),
		.x1       (x_res[1]),
		.color_in (color_sn[DIV_LAT-1]),
		.glyph_in (glyph_sn[DIV_LAT-1]),
		.can_load (can_load),
		.tri_out  (tri_out)
	);

	// the second triangle of a split follows directly in the output register
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		tri_out.valid && tri_out.ready && !tri_out.last |=> tri_out.valid && tri_out.last)
		else $error("second triangle missing after non-last transaction");

	// a held pipeline keeps its last stage
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_fin))
		else $error("pipeline moved while held");

	// a surviving triangle that leaves the pipeline shows up at the output
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		v_fin && adv && cls_fin.n_in != 2'd0 |=> tri_out.valid)
		else $error("result lost between pipeline and output register");

endmodule
`default_nettype wire

// ===== design/clp_dist.sv =====
// Signed plane distance of each vertex and inside/outside classification, three stages.
`default_nettype none
module clp_dist import clp_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic signed [W-1:0] vin [3][3],
	input  wire logic [15:0]         color_in,
	input  wire logic [15:0]         glyph_in,
	input  wire logic signed [W-1:0] point [3],
	input  wire logic signed [W-1:0] normal [3],
	output logic                     valid_s3,
	output logic signed [W-1:0]      vtx_s3 [3][3],
	output logic [15:0]              color_s3,
	output logic [15:0]              glyph_s3,
	output logic signed [2*W+2:0]    dist_s3 [3],
	output clp_class_t               cls_s3
);
	localparam int DW = 2*W + 3;

	logic                  valid_s1, valid_s2;
	logic signed [W-1:0]   vtx_s1 [3][3];
	logic signed [W-1:0]   vtx_s2 [3][3];
	logic signed [W:0]     delta_s1 [3][3];
	logic signed [2*W:0]   prod_s2 [3][3];
	logic [15:0]           color_s1, color_s2, glyph_s1, glyph_s2;
	logic signed [DW-1:0]  dsum [3];
	logic [2:0]            neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dsum[i] = DW'(prod_s2[i][0]) + DW'(prod_s2[i][1]) + DW'(prod_s2[i][2]);
			neg[i]  = dsum[i][DW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					delta_s1[i][k] <= {vin[i][k][W-1], vin[i][k]} - {point[k][W-1], point[k]};
					prod_s2[i][k]  <= normal[k] * delta_s1[i][k];
				end
				dist_s3[i] <= dsum[i];
			end
			vtx_s1   <= vin;
			vtx_s2   <= vtx_s1;
			vtx_s3   <= vtx_s2;
			color_s1 <= color_in;
			color_s2 <= color_s1;
			color_s3 <= color_s2;
			glyph_s1 <= glyph_in;
			glyph_s2 <= glyph_s1;
			glyph_s3 <= glyph_s2;
			cls_s3   <= classify(neg);
		end
	end

endmodule
`default_nettype wire

// ===== design/clp_div.sv =====
// One intersection coordinate: a + round(|b-a|*d(a)/den) with sign, bit-per-stage divider.
`default_nettype none
module clp_div #(
	parameter int W = 32
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [W-1:0]   a,
	input  wire logic [W-1:0]          mag,
	input  wire logic                  neg,
	input  wire logic [2*W+1:0]        da,
	input  wire logic [2*W+2:0]        den,
	output logic signed [W-1:0]        res
);
	localparam int RW = 2*W + 3;
	localparam int NW = 3*W + 2;

	logic [3*W-1:0]        da_pad;
	logic [2*W-1:0]        pp_s1 [3];
	logic signed [W-1:0]   a_s1;
	logic                  neg_s1;
	logic [RW-1:0]         den_s1;
	logic [4*W-1:0]        sum_full;

	logic [RW-1:0]         rem_sd [W+1];
	logic [W-1:0]          quo_sd [W+1];
	logic [W-1:0]          nlo_sd [W+1];
	logic signed [W-1:0]   a_sd   [W+1];
	logic                  neg_sd [W+1];
	logic [RW-1:0]         den_sd [W+1];

	logic                  round_up;
	logic [W:0]            qq;
	logic [W+1:0]          sv;

	assign da_pad   = {{(W-2){1'b0}}, da};
	assign sum_full = ((4*W)'(pp_s1[2]) << (2*W)) + ((4*W)'(pp_s1[1]) << W)
		+ (4*W)'(pp_s1[0]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) pp_s1[c] <= mag * da_pad[c*W +: W];
			a_s1      <= a;
			neg_s1    <= neg;
			den_s1    <= den;
			rem_sd[0] <= RW'(sum_full[NW-1:W]);
			quo_sd[0] <= '0;
			nlo_sd[0] <= sum_full[W-1:0];
			a_sd[0]   <= a_s1;
			neg_sd[0] <= neg_s1;
			den_sd[0] <= den_s1;
		end
	end

	for (genvar j = 1; j <= W; j++) begin : g_step
		logic [RW:0] trial;
		logic        ge;
		assign trial = {rem_sd[j-1], nlo_sd[j-1][W-j]};
		assign ge    = trial >= {1'b0, den_sd[j-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[j] <= ge ? RW'(trial - {1'b0, den_sd[j-1]}) : trial[RW-1:0];
				quo_sd[j] <= {quo_sd[j-1][W-2:0], ge};
				nlo_sd[j] <= nlo_sd[j-1];
				a_sd[j]   <= a_sd[j-1];
				neg_sd[j] <= neg_sd[j-1];
				den_sd[j] <= den_sd[j-1];
			end
		end
	end

	// round half up on the magnitude, apply sign, clamp to the coordinate range
	assign round_up = {rem_sd[W], 1'b0} >= {1'b0, den_sd[W]};
	assign qq       = {1'b0, quo_sd[W]} + (W+1)'(round_up);
	assign sv       = neg_sd[W] ? {a_sd[W][W-1], a_sd[W][W-1], a_sd[W]} - {1'b0, qq}
	                            : {a_sd[W][W-1], a_sd[W][W-1], a_sd[W]} + {1'b0, qq};

	always_ff @(posedge clk) begin
		if (en) begin
			if (sv[W+1:W-1] == 3'b000 || sv[W+1:W-1] == 3'b111)
				res <= sv[W-1:0];
			else if (!sv[W+1])
				res <= {1'b0, {(W-1){1'b1}}};
			else
				res <= {1'b1, {(W-1){1'b0}}};
		end
	end

endmodule
`default_nettype wire

// ===== design/clp_emit.sv =====
// Output register: builds up to two result triangles and hands them out one per transaction.
`default_nettype none
module clp_emit import clp_pkg::*; #(
	parameter int W = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire clp_class_t          cls,
	input  wire logic signed [W-1:0] vtx [3][3],
	input  wire logic signed [W-1:0] x0 [3],
	input  wire logic signed [W-1:0] x1 [3],
	input  wire logic [15:0]         color_in,
	input  wire logic [15:0]         glyph_in,
	output logic                     can_load,
	clp_out_if.source                tri_out
);
	logic                full_q, second_q, two_q;
	logic signed [W-1:0] t0_q [3][3];
	logic signed [W-1:0] t1_q [3][3];
	logic signed [W-1:0] t0 [3][3];
	logic signed [W-1:0] t1 [3][3];
	logic signed [W-1:0] sel [3][3];
	logic [15:0]         color_q, glyph_q;
	logic                take, done, load;

	assign take     = full_q && tri_out.ready;
	assign done     = take && (!two_q || second_q);
	assign can_load = !full_q || done;
	assign load     = in_valid && can_load && (cls.n_in != 2'd0);

	always_comb begin
		t0 = vtx;
		t1[0] = vtx[cls.i1];
		t1[1] = x0;
		t1[2] = x1;
		unique case (cls.n_in)
			2'd1: begin
				t0[0] = vtx[cls.i0];
				t0[1] = x0;
				t0[2] = x1;
			end
			2'd2: begin
				t0[0] = vtx[cls.i0];
				t0[1] = vtx[cls.i1];
				t0[2] = x0;
			end
			2'd0, 2'd3: t0 = vtx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q   <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			full_q   <= 1'b1;
			second_q <= 1'b0;
		end else if (done) begin
			full_q   <= 1'b0;
			second_q <= 1'b0;
		end else if (take) begin
			second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			t0_q    <= t0;
			t1_q    <= t1;
			two_q   <= (cls.n_in == 2'd2);
			color_q <= color_in;
			glyph_q <= glyph_in;
		end
	end

	assign sel = second_q ? t1_q : t0_q;

	assign tri_out.valid     = full_q;
	assign tri_out.out_v1_x  = sel[0][0];
	assign tri_out.out_v1_y  = sel[0][1];
	assign tri_out.out_v1_z  = sel[0][2];
	assign tri_out.out_v2_x  = sel[1][0];
	assign tri_out.out_v2_y  = sel[1][1];
	assign tri_out.out_v2_z  = sel[1][2];
	assign tri_out.out_v3_x  = sel[2][0];
	assign tri_out.out_v3_y  = sel[2][1];
	assign tri_out.out_v3_z  = sel[2][2];
	assign tri_out.out_color = color_q;
	assign tri_out.out_glyph = glyph_q;
	assign tri_out.last      = !two_q || second_q;

endmodule
`default_nettype wire

// ===== dv/tb_triangle_plane_clipper_top.sv =====
// Self-checking testbench for the triangle plane clipper: predicts clipped triangles and checks them in order.
`default_nettype none
module tb_triangle_plane_clipper_top;
	import clp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW        = 32;
	localparam int FRAC      = 16;
	localparam int IDLE_MAX  = 6000;   // cycles without any transaction before giving up
	localparam int SETTLE    = 100;    // covers the pipeline latency
	localparam int HOLD_OFF  = 400;
	localparam int PHASE_LEN = 75;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [159:0]  wide_t;

	typedef struct {
		coord_t      v[9];
		logic [15:0] color;
		logic [15:0] glyph;
	} tri_t;

	typedef struct {
		coord_t      v[9];
		logic [15:0] color;
		logic [15:0] glyph;
		logic        last;
	} clip_tri_t;

	// Expected clipped triangles in output order, built from each accepted input triangle.
	class clip_scoreboard;
		clip_tri_t pending[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		function coord_t cross_coord(wide_t a, wide_t b, wide_t da, wide_t db);
			wide_t den, num, mag, q, r, res;
			den = da - db;
			num = (b - a) * da;
			mag = (num < 0) ? -num : num;
			q = mag / den;
			r = mag % den;
			if (2 * r >= den)
				q = q + 1;
			res = a + ((num < 0) ? -q : q);
			if (res > wide_t'(32'sh7fffffff))
				res = wide_t'(32'sh7fffffff);
			if (res < wide_t'(-64'sd2147483648))
				res = wide_t'(-64'sd2147483648);
			return res[CW-1:0];
		endfunction

		function void note(tri_t t, coord_t pt[3], coord_t nrm[3]);
			wide_t     d[3];
			wide_t     pv[3][3];
			int        ins[$], outs[$];
			clip_tri_t o;
			int        a, b, c;
			coord_t    x0[3], x1[3];
			for (int i = 0; i < 3; i++) begin
				d[i] = 0;
				for (int k = 0; k < 3; k++) begin
					pv[i][k] = t.v[i*3+k];
					d[i] = d[i] + wide_t'(nrm[k]) * (pv[i][k] - wide_t'(pt[k]));
				end
				if (d[i] < 0)
					outs.push_back(i);
				else
					ins.push_back(i);
			end
			o.color = t.color;
			o.glyph = t.glyph;
			o.last = 1'b1;
			case (ins.size())
				3: begin
					o.v = t.v;
					pending.push_back(o);
				end
				1: begin
					a = ins[0];
					for (int k = 0; k < 3; k++) begin
						o.v[k]   = t.v[a*3+k];
						o.v[3+k] = cross_coord(pv[a][k], pv[outs[0]][k], d[a], d[outs[0]]);
						o.v[6+k] = cross_coord(pv[a][k], pv[outs[1]][k], d[a], d[outs[1]]);
					end
					pending.push_back(o);
				end
				2: begin
					a = ins[0];
					b = ins[1];
					c = outs[0];
					for (int k = 0; k < 3; k++) begin
						x0[k] = cross_coord(pv[a][k], pv[c][k], d[a], d[c]);
						x1[k] = cross_coord(pv[b][k], pv[c][k], d[b], d[c]);
					end
					// quad splits into (a, b, X(a,c)) then (b, X(a,c), X(b,c))
					for (int k = 0; k < 3; k++) begin
						o.v[k]   = t.v[a*3+k];
						o.v[3+k] = t.v[b*3+k];
						o.v[6+k] = x0[k];
					end
					o.last = 1'b0;
					pending.push_back(o);
					for (int k = 0; k < 3; k++) begin
						o.v[k]   = t.v[b*3+k];
						o.v[3+k] = x0[k];
						o.v[6+k] = x1[k];
					end
					o.last = 1'b1;
					pending.push_back(o);
				end
				default: ;
			endcase
		endfunction

		function void check(clip_tri_t got);
			clip_tri_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected triangle, last=%0b", $time, got.last);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (got.v[k] !== want.v[k]) begin
					$display("%0t: vertex coord %0d expected %h actual %h",
						$time, k, want.v[k], got.v[k]);
					errors++;
				end
			if (got.color !== want.color) begin
				$display("%0t: color expected %h actual %h", $time, want.color, got.color);
				errors++;
			end
			if (got.glyph !== want.glyph) begin
				$display("%0t: glyph expected %h actual %h", $time, want.glyph, got.glyph);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	clp_in_if  #(.W(CW)) tri_in();
	clp_out_if #(.W(CW)) tri_out();
	clp_cfg_if #(.W(CW)) cfg();

	triangle_plane_clipper_top #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tri_in (tri_in.sink),
		.tri_out(tri_out.source),
		.cfg    (cfg.sink)
	);

	clip_scoreboard sb = new();

	// testbench copy of the plane registers, updated on each accepted write
	coord_t plane_pt[3];
	coord_t plane_nrm[3];

	int  send_pct;
	int  recv_pct;
	bit  hold_req;
	int  quiet_cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Sample every channel at the rising edge; the DUT has not yet applied its updates.
	always @(posedge clk) begin
		clip_tri_t got;
		tri_t      t;
		bit        moved;
		moved = 1'b0;
		if (arst_n && cfg.valid && cfg.ready) begin
			moved = 1'b1;
			case (cfg_reg_e'(cfg.index))
				REG_POINT_X:  plane_pt[0]  = cfg.data;
				REG_POINT_Y:  plane_pt[1]  = cfg.data;
				REG_POINT_Z:  plane_pt[2]  = cfg.data;
				REG_NORMAL_X: plane_nrm[0] = cfg.data;
				REG_NORMAL_Y: plane_nrm[1] = cfg.data;
				REG_NORMAL_Z: plane_nrm[2] = cfg.data;
				default: ;
			endcase
		end
		if (arst_n && tri_in.valid && tri_in.ready) begin
			moved = 1'b1;
			t.v = '{tri_in.v1_x, tri_in.v1_y, tri_in.v1_z, tri_in.v2_x, tri_in.v2_y,
				tri_in.v2_z, tri_in.v3_x, tri_in.v3_y, tri_in.v3_z};
			t.color = tri_in.color;
			t.glyph = tri_in.glyph;
			sb.note(t, plane_pt, plane_nrm);
		end
		if (arst_n && tri_out.valid && tri_out.ready) begin
			moved = 1'b1;
			got.v = '{tri_out.out_v1_x, tri_out.out_v1_y, tri_out.out_v1_z,
				tri_out.out_v2_x, tri_out.out_v2_y, tri_out.out_v2_z,
				tri_out.out_v3_x, tri_out.out_v3_y, tri_out.out_v3_z};
			got.color = tri_out.out_color;
			got.glyph = tri_out.out_glyph;
			got.last = tri_out.last;
			sb.check(got);
		end
		// watchdog: count cycles in which no transaction happens anywhere
		if (moved)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request so the pipeline backs up.
	initial begin
		tri_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				tri_out.ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
				hold_req = 1'b0;
			end
			tri_out.ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	// Offer one triangle and hold it until taken; valid stays high on return.
	task automatic send_tri(tri_t t);
		while ($urandom_range(99) < send_pct) begin
			tri_in.valid <= 1'b0;
			@(negedge clk);
		end
		tri_in.valid <= 1'b1;
		{tri_in.v1_x, tri_in.v1_y, tri_in.v1_z} <= {t.v[0], t.v[1], t.v[2]};
		{tri_in.v2_x, tri_in.v2_y, tri_in.v2_z} <= {t.v[3], t.v[4], t.v[5]};
		{tri_in.v3_x, tri_in.v3_y, tri_in.v3_z} <= {t.v[6], t.v[7], t.v[8]};
		tri_in.color <= t.color;
		tri_in.glyph <= t.glyph;
		do @(posedge clk); while (!tri_in.ready);
		@(negedge clk);
	endtask

	// Offer one register write and hold it until taken; valid stays high on return.
	task automatic write_reg(cfg_reg_e idx, coord_t value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	// Drop valid, wait out every expected triangle, then let clipped-away work drain.
	task automatic drain();
		tri_in.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic load_plane(coord_t px, coord_t py, coord_t pz,
		coord_t nx, coord_t ny, coord_t nz);
		write_reg(REG_POINT_X, px);
		write_reg(REG_POINT_Y, py);
		write_reg(REG_POINT_Z, pz);
		write_reg(REG_NORMAL_X, nx);
		write_reg(REG_NORMAL_Y, ny);
		write_reg(REG_NORMAL_Z, nz);
		cfg.valid <= 1'b0;
	endtask

	// Mostly small offsets around the plane point so triangles straddle it; some wide values.
	function automatic coord_t pick_coord(int axis);
		case ($urandom_range(9))
			0: return 32'sh80000000;
			1: return 32'sh7fffffff;
			2, 3: return $urandom;
			default: return plane_pt[axis] + coord_t'($urandom_range(32'h40000) - 32'h20000);
		endcase
	endfunction

	function automatic tri_t random_tri();
		tri_t t;
		for (int k = 0; k < 9; k++)
			t.v[k] = pick_coord(k % 3);
		t.color = $urandom;
		t.glyph = $urandom;
		return t;
	endfunction

	// Random triangles, idling receiver-heavy, then sender-heavy, then not at all.
	task automatic random_phase(int count, bit pause_midway);
		for (int i = 0; i < count; i++) begin
			if (i < count / 3) begin
				send_pct = 27;
				recv_pct = 71;
			end else if (i < 2 * count / 3) begin
				send_pct = 71;
				recv_pct = 27;
			end else begin
				send_pct = 0;
				recv_pct = 0;
			end
			if (pause_midway && i == count / 2) begin
				// hold the sender until every expected triangle has come out
				tri_in.valid <= 1'b0;
				@(negedge clk);
				while (sb.pending.size() != 0) @(negedge clk);
			end
			send_tri(random_tri());
		end
	endtask

	initial begin
		tri_t   t;
		coord_t zpick[4];
		arst_n = 1'b0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		send_pct = 0;
		recv_pct = 0;
		tri_in.valid = 1'b0;
		{tri_in.v1_x, tri_in.v1_y, tri_in.v1_z} = '0;
		{tri_in.v2_x, tri_in.v2_y, tri_in.v2_z} = '0;
		{tri_in.v3_x, tri_in.v3_y, tri_in.v3_z} = '0;
		tri_in.color = '0;
		tri_in.glyph = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_POINT_X;
		cfg.data = '0;
		plane_pt = '{0, 0, 0};
		plane_nrm = '{0, 0, 32'sd1 <<< FRAC};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, reset plane z >= 0: walk every inside/outside pattern.
		// z values: on the plane, positive, negative, extreme negative.
		zpick = '{32'sd0, 32'sh00030000, -32'sh00020000, 32'sh80000000};
		for (int pat = 0; pat < 8; pat++) begin
			for (int k = 0; k < 9; k++)
				t.v[k] = coord_t'($urandom_range(32'h80000)) - 32'sh40000;
			for (int i = 0; i < 3; i++)
				t.v[i*3+2] = pat[i] ? zpick[2 + (pat % 2)] : zpick[i % 2];
			t.color = pat[0] ? 16'hffff : 16'h0000;
			t.glyph = pat[1] ? 16'h0000 : 16'hffff;
			send_tri(t);
		end
		// coordinate extremes with the plane crossing at the far end of an edge
		for (int j = 0; j < 8; j++) begin
			for (int k = 0; k < 9; k++)
				t.v[k] = ((j + k) % 2) ? 32'sh7fffffff : 32'sh80000000;
			t.v[2 + 3 * (j % 3)] = 32'sh7fffffff;
			t.color = $urandom;
			t.glyph = $urandom;
			send_tri(t);
		end
		// vertices exactly on the plane count as inside
		t.v = '{1, 2, 0, -5, 7, 0, 32'sh7fffffff, 32'sh80000000, 0};
		send_tri(t);
		t.v = '{1, 2, 0, -5, 7, -1, 3, 3, 0};
		send_tri(t);
		random_phase(PHASE_LEN, 1'b0);
		drain();

		// x plane through the origin; long receiver hold-off while the sender keeps going
		load_plane(0, 0, 0, 32'sd1 <<< FRAC, 0, 0);
		hold_req = 1'b1;
		random_phase(PHASE_LEN, 1'b0);
		drain();

		// zero normal passes every triangle; sender pauses midway until all is out
		load_plane($urandom, $urandom, $urandom, 0, 0, 0);
		random_phase(PHASE_LEN, 1'b1);
		drain();

		// extreme register values
		load_plane(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff);
		random_phase(PHASE_LEN, 1'b0);
		drain();

		// moderate random plane near the origin
		load_plane(coord_t'($urandom_range(32'h40000)) - 32'sh20000,
			coord_t'($urandom_range(32'h40000)) - 32'sh20000,
			coord_t'($urandom_range(32'h40000)) - 32'sh20000,
			coord_t'($urandom_range(32'h20000)) - 32'sh10000,
			coord_t'($urandom_range(32'h20000)) - 32'sh10000,
			coord_t'($urandom_range(32'h20000)) - 32'sh10000);
		random_phase(PHASE_LEN, 1'b0);
		drain();

		// fully random plane
		load_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		random_phase(PHASE_LEN, 1'b0);
		drain();

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
